// File: rtl/msa_pkg.sv
// Package for the multi-class slot allocator: widths, request/status codes,
// register indexes and the configuration and command structs.
// No dependencies; every other file imports it.
package msa_pkg;

    // Geometry
    localparam int TOTAL_SLOTS = 64;
    localparam int MAX_CLASSES = 3;
    localparam int SLOT_W      = $clog2(TOTAL_SLOTS);
    localparam int RNG_W       = $clog2(TOTAL_SLOTS + 1);
    localparam int CLS_W       = 2;
    localparam int CLS_SLOTS   = 1 << CLS_W;

    // Field widths
    localparam int REQ_W    = 2;
    localparam int STAT_W   = 2;
    localparam int ALIGN_W  = 9;
    localparam int CNT_W    = 7;
    localparam int SIZE_W   = 17;
    localparam int SUM_W    = CNT_W + 2;
    localparam int OFF_W    = 22;
    localparam int MUL_W    = SIZE_W + CNT_W;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = SIZE_W;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ALIGN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_C0_CNT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_C0_SIZE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_C1_CNT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_C1_SIZE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_C2_CNT  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_C2_SIZE = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CLASSES = 3'd7;

    // Reset values
    localparam logic [ALIGN_W-1:0] ALIGN_RST   = 9'd256;
    localparam logic [SIZE_W-1:0]  SIZE_RST    = 17'd1;
    localparam logic [CLS_W-1:0]   CLASSES_RST = 2'd1;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_ALLOC   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_RELEASE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_LOOKUP  = 2'd2;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD  = 2'd2;

    // Configuration registers as seen by the datapath
    typedef struct packed {
        logic [ALIGN_W-1:0]                  alignment;
        logic [MAX_CLASSES-1:0][CNT_W-1:0]   count;
        logic [MAX_CLASSES-1:0][SIZE_W-1:0]  size;
        logic [CLS_W-1:0]                    classes_in_use;
    } t_cfg;

    // Sequencer commands to the datapath
    typedef struct packed {
        logic load;     // capture a new request
        logic base0;    // region offset of class 1
        logic base1;    // region offset of class 2
        logic find;     // pick the slot and class
        logic finish;   // slot offset, map update, result out
    } t_cmd;

endpackage

// File: rtl/msa_cfg.sv
// Configuration register file of the slot allocator.
// Depends on msa_pkg.
module msa_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [msa_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [msa_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output msa_pkg::t_cfg                   o_cfg
);
    import msa_pkg::*;

    t_cfg r_cfg;

    // Register writes, masked to each register's width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.alignment      <= ALIGN_RST;
            r_cfg.count          <= '0;
            r_cfg.size           <= {MAX_CLASSES{SIZE_RST}};
            r_cfg.classes_in_use <= CLASSES_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_ALIGN:   r_cfg.alignment      <= i_cfg_data[ALIGN_W-1:0];
                REG_C0_CNT:  r_cfg.count[0]       <= i_cfg_data[CNT_W-1:0];
                REG_C0_SIZE: r_cfg.size[0]        <= i_cfg_data[SIZE_W-1:0];
                REG_C1_CNT:  r_cfg.count[1]       <= i_cfg_data[CNT_W-1:0];
                REG_C1_SIZE: r_cfg.size[1]        <= i_cfg_data[SIZE_W-1:0];
                REG_C2_CNT:  r_cfg.count[2]       <= i_cfg_data[CNT_W-1:0];
                REG_C2_SIZE: r_cfg.size[2]        <= i_cfg_data[SIZE_W-1:0];
                REG_CLASSES: r_cfg.classes_in_use <= i_cfg_data[CLS_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/msa_ctrl.sv
// Sequencer of the slot allocator: steps one request through its four
// datapath phases. Depends on msa_pkg.
module msa_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    output logic           o_busy,
    output msa_pkg::t_cmd  o_cmd
);
    import msa_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_BASE0 = 3'd1;
    localparam logic [2:0] S_BASE1 = 3'd2;
    localparam logic [2:0] S_FIND  = 3'd3;
    localparam logic [2:0] S_OFFS  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_start) n_state = S_BASE0;
            S_BASE0: n_state = S_BASE1;
            S_BASE1: n_state = S_FIND;
            S_FIND:  n_state = S_OFFS;
            S_OFFS:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Commands
    assign o_busy       = (r_state != S_IDLE);
    assign o_cmd.load   = (r_state == S_IDLE) && i_start;
    assign o_cmd.base0  = (r_state == S_BASE0);
    assign o_cmd.base1  = (r_state == S_BASE1);
    assign o_cmd.find   = (r_state == S_FIND);
    assign o_cmd.finish = (r_state == S_OFFS);

endmodule

// File: rtl/msa_dpath.sv
// Datapath of the slot allocator: busy map, class ranges, free-slot
// search, shared offset multiplier and result registers. Depends on msa_pkg.
module msa_dpath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  msa_pkg::t_cfg                i_cfg,
    input  msa_pkg::t_cmd                i_cmd,
    input  logic [msa_pkg::REQ_W-1:0]    i_req_type,
    input  logic [msa_pkg::CLS_W-1:0]    i_class_index,
    input  logic [msa_pkg::SLOT_W-1:0]   i_slot_number,
    output logic                         o_strobe,
    output logic [msa_pkg::STAT_W-1:0]   o_status,
    output logic [msa_pkg::SLOT_W-1:0]   o_granted_slot,
    output logic [msa_pkg::OFF_W-1:0]    o_byte_offset,
    output logic [msa_pkg::SIZE_W-1:0]   o_slot_bytes,
    output logic [msa_pkg::CLS_W-1:0]    o_slot_class
);
    import msa_pkg::*;

    function automatic logic [RNG_W-1:0] clip(input logic [SUM_W-1:0] v);
        return (v > SUM_W'(TOTAL_SLOTS)) ? RNG_W'(TOTAL_SLOTS) : v[RNG_W-1:0];
    endfunction

    // Request and intermediate registers
    logic [REQ_W-1:0]       r_req_type;
    logic [CLS_W-1:0]       r_class_index;
    logic [SLOT_W-1:0]      r_slot_number;
    logic [OFF_W-1:0]       r_off1;
    logic [OFF_W-1:0]       r_off2;
    logic [STAT_W-1:0]      r_status;
    logic [SLOT_W-1:0]      r_slot;
    logic [CLS_W-1:0]       r_cls;
    logic [SLOT_W-1:0]      r_idx;
    logic [TOTAL_SLOTS-1:0] r_busy_map;

    // Result registers
    logic                   r_strobe;
    logic [STAT_W-1:0]      r_out_status;
    logic [SLOT_W-1:0]      r_out_slot;
    logic [OFF_W-1:0]       r_out_offset;
    logic [SIZE_W-1:0]      r_out_bytes;
    logic [CLS_W-1:0]       r_out_class;

    // Per-class geometry; entry 3 is an empty, inactive class
    logic [SIZE_W-1:0]      stride   [CLS_SLOTS];
    logic [SIZE_W-1:0]      csize    [CLS_SLOTS];
    logic [RNG_W-1:0]       rng_s    [CLS_SLOTS];
    logic [RNG_W-1:0]       rng_e    [CLS_SLOTS];
    logic [CLS_SLOTS-1:0]   active;
    logic [SUM_W-1:0]       sum1, sum2, sum3;

    always_comb begin
        for (int c = 0; c < CLS_SLOTS; c++) begin
            stride[c] = '0;
            csize[c]  = '0;
            active[c] = (CLS_W'(c) < i_cfg.classes_in_use);
        end
        for (int c = 0; c < MAX_CLASSES; c++) begin
            csize[c]  = i_cfg.size[c];
            stride[c] = (i_cfg.size[c] > SIZE_W'(i_cfg.alignment)) ?
                        i_cfg.size[c] : SIZE_W'(i_cfg.alignment);
        end
        sum1 = SUM_W'(i_cfg.count[0]);
        sum2 = sum1 + SUM_W'(i_cfg.count[1]);
        sum3 = sum2 + SUM_W'(i_cfg.count[2]);
        rng_s[0] = '0;
        rng_e[0] = clip(sum1);
        rng_s[1] = clip(sum1);
        rng_e[1] = clip(sum2);
        rng_s[2] = clip(sum2);
        rng_e[2] = clip(sum3);
        rng_s[3] = RNG_W'(TOTAL_SLOTS);
        rng_e[3] = RNG_W'(TOTAL_SLOTS);
    end

    // Allocate: lowest free slot inside the requested class range
    logic [TOTAL_SLOTS-1:0] range_mask;
    logic [TOTAL_SLOTS-1:0] free_map;
    logic [TOTAL_SLOTS-1:0] lowest;
    logic [SLOT_W-1:0]      free_pos;
    logic                   free_found;

    always_comb begin
        for (int i = 0; i < TOTAL_SLOTS; i++) begin
            range_mask[i] = (RNG_W'(i) >= rng_s[r_class_index]) &&
                            (RNG_W'(i) <  rng_e[r_class_index]);
        end
        free_map   = ~r_busy_map & range_mask;
        free_found = |free_map;
        lowest     = free_map & (~free_map + 1'b1);
        free_pos   = '0;
        for (int i = 0; i < TOTAL_SLOTS; i++) begin
            free_pos = free_pos | (lowest[i] ? SLOT_W'(i) : '0);
        end
    end

    // Release / lookup: class that holds the given slot
    logic             loc_hit;
    logic [CLS_W-1:0] loc_cls;

    always_comb begin
        loc_hit = 1'b0;
        loc_cls = '0;
        for (int c = MAX_CLASSES - 1; c >= 0; c--) begin
            if (active[c] && (RNG_W'(r_slot_number) >= rng_s[c]) &&
                (RNG_W'(r_slot_number) < rng_e[c])) begin
                loc_hit = 1'b1;
                loc_cls = CLS_W'(c);
            end
        end
    end

    // Find-phase decision
    logic [STAT_W-1:0] n_status;
    logic [SLOT_W-1:0] n_slot;
    logic [CLS_W-1:0]  n_cls;
    logic [RNG_W-1:0]  n_diff;

    always_comb begin
        n_status = ST_BAD;
        n_slot   = r_slot_number;
        n_cls    = loc_cls;
        case (r_req_type)
            REQ_ALLOC: begin
                n_slot = free_pos;
                n_cls  = r_class_index;
                if (active[r_class_index]) begin
                    n_status = free_found ? ST_OK : ST_FULL;
                end
            end
            REQ_RELEASE: begin
                if (loc_hit && r_busy_map[r_slot_number]) begin
                    n_status = ST_OK;
                end
            end
            REQ_LOOKUP: begin
                if (loc_hit) begin
                    n_status = ST_OK;
                end
            end
            default: n_status = ST_BAD;
        endcase
        n_diff = RNG_W'(n_slot) - rng_s[n_cls];
    end

    // Shared multiplier: region sizes, then stride times index in class
    logic [SIZE_W-1:0] mul_a;
    logic [CNT_W-1:0]  mul_b;
    logic [MUL_W-1:0]  mul_p;
    logic [OFF_W-1:0]  base_off;

    always_comb begin
        if (i_cmd.base0) begin
            mul_a = stride[0];
            mul_b = i_cfg.count[0];
        end else if (i_cmd.base1) begin
            mul_a = stride[1];
            mul_b = i_cfg.count[1];
        end else begin
            mul_a = stride[r_cls];
            mul_b = CNT_W'(r_idx);
        end
        mul_p = MUL_W'(mul_a) * MUL_W'(mul_b);
        case (r_cls)
            2'd1:    base_off = r_off1;
            2'd2:    base_off = r_off2;
            default: base_off = '0;
        endcase
    end

    // Request capture and phase registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req_type    <= i_req_type;
            r_class_index <= i_class_index;
            r_slot_number <= i_slot_number;
        end
        if (i_cmd.base0) begin
            r_off1 <= mul_p[OFF_W-1:0];
        end
        if (i_cmd.base1) begin
            r_off2 <= r_off1 + mul_p[OFF_W-1:0];
        end
        if (i_cmd.find) begin
            r_status <= n_status;
            r_slot   <= n_slot;
            r_cls    <= n_cls;
            r_idx    <= n_diff[SLOT_W-1:0];
        end
    end

    // Busy map update on a successful allocate or release
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy_map <= '0;
        end else if (i_cmd.finish && (r_status == ST_OK)) begin
            if (r_req_type == REQ_ALLOC) begin
                r_busy_map[r_slot] <= 1'b1;
            end else if (r_req_type == REQ_RELEASE) begin
                r_busy_map[r_slot] <= 1'b0;
            end
        end
    end

    // Result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.finish;
        end
    end

    // Result payload; fields stay zero unless the request succeeded
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_status <= r_status;
            if (r_status == ST_OK) begin
                r_out_slot   <= r_slot;
                r_out_offset <= base_off + mul_p[OFF_W-1:0];
                r_out_class  <= r_cls;
                r_out_bytes  <= (r_req_type == REQ_LOOKUP) ? csize[r_cls] : '0;
            end else begin
                r_out_slot   <= '0;
                r_out_offset <= '0;
                r_out_class  <= '0;
                r_out_bytes  <= '0;
            end
        end
    end

    assign o_strobe       = r_strobe;
    assign o_status       = r_out_status;
    assign o_granted_slot = r_out_slot;
    assign o_byte_offset  = r_out_offset;
    assign o_slot_bytes   = r_out_bytes;
    assign o_slot_class   = r_out_class;

endmodule

// File: rtl/multi_class_slot_allocator.sv
// Top level of the multi-class slot allocator: config registers, sequencer
// and datapath. Depends on msa_pkg, msa_cfg, msa_ctrl, msa_dpath.
//
//   channel   | handshake              | payload
//   ----------+------------------------+--------------------------------------
//   request   | start / busy           | i_req_type, i_class_index,
//             |                        | i_slot_number
//   result    | o_strobe (one cycle)   | o_status, o_granted_slot,
//             |                        | o_byte_offset, o_slot_bytes,
//             |                        | o_slot_class
//   config    | i_cfg_we               | i_cfg_index, i_cfg_data
//
// A request steps through states BASE0, BASE1, FIND and OFFS; the result
// strobe is registered from OFFS. The shared multiplier is used three times
// in sequence (two region offsets, then the slot offset). busy drops in the
// strobe cycle, so the next request is taken at the edge that ends it; none
// is taken while busy. Reset is synchronous: all slots free, config at
// defaults. Results hold until the next one; there is no back-pressure.
module multi_class_slot_allocator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [msa_pkg::REQ_W-1:0]       i_req_type,
    input  logic [msa_pkg::CLS_W-1:0]       i_class_index,
    input  logic [msa_pkg::SLOT_W-1:0]      i_slot_number,
    output logic                            o_strobe,
    output logic [msa_pkg::STAT_W-1:0]      o_status,
    output logic [msa_pkg::SLOT_W-1:0]      o_granted_slot,
    output logic [msa_pkg::OFF_W-1:0]       o_byte_offset,
    output logic [msa_pkg::SIZE_W-1:0]      o_slot_bytes,
    output logic [msa_pkg::CLS_W-1:0]       o_slot_class,
    input  logic                            i_cfg_we,
    input  logic [msa_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [msa_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import msa_pkg::*;

    t_cfg cfg;
    t_cmd cmd;

    msa_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    msa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_cmd   (cmd)
    );

    msa_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_cmd          (cmd),
        .i_req_type     (i_req_type),
        .i_class_index  (i_class_index),
        .i_slot_number  (i_slot_number),
        .o_strobe       (o_strobe),
        .o_status       (o_status),
        .o_granted_slot (o_granted_slot),
        .o_byte_offset  (o_byte_offset),
        .o_slot_bytes   (o_slot_bytes),
        .o_slot_class   (o_slot_class)
    );

endmodule
